/* design/csev_pkg.sv */
// Shared types and constants of the cubic spline evaluator.
package csev_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int ADDR_W      = $clog2(MAX_POINTS);
  localparam int COORD_WIDTH = 32;
  localparam int CNT_W       = 7;
  localparam int T_W         = 17;
  localparam int W_W         = 52;
  localparam int PT_W        = 3 * COORD_WIDTH;
  localparam int NBANK       = 4;

  localparam logic [T_W-1:0]   T_ONE     = 17'd65536;
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_POINTS);
  localparam logic             CMD_WRITE = 1'b0;
  localparam logic             CMD_EVAL  = 1'b1;
  localparam logic             KIND_BSPL = 1'b0;
  localparam logic             KIND_CR   = 1'b1;
  localparam logic             REG_KIND  = 1'b0;
  localparam logic             REG_COUNT = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [W_W-1:0]         weight_t;

  typedef struct packed {
    logic                   cmd;
    logic [ADDR_W-1:0]      point_index;
    coord_t                 point_x;
    coord_t                 point_y;
    coord_t                 point_z;
    logic [T_W-1:0]         t_param;
  } csev_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   too_few_points;
  } csev_out_t;

endpackage

/* design/cubic_spline_evaluator_core.sv */
// Top level of the cubic spline evaluator: APB registers, point table, pipeline.
//
// Evaluates a uniform cubic B-spline or a Catmull-Rom spline (end points
// duplicated) over a table of up to 64 Q16.16 control points. Pulse start with
// a command: a write stores one point, an evaluate returns one curve point.
// busy never rises, so one command can be issued every clock cycle. An
// evaluate returns its result on out_data with out_valid high for exactly one
// cycle; writes return nothing. The twelve-stage datapath covers segment split,
// table read (four banks, so all four neighbors are read at once), weight
// build, partial products, sums, rounding and a two-digit divide by three.
// The receiver cannot stall the result; take it in the cycle it is shown.
// Write spline_kind and point_count only while no evaluate is in flight.
// With too few points the result is zero and too_few_points is set.
// Reading an evaluate over slots never written since reset gives undefined
// coordinates.
module cubic_spline_evaluator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  csev_pkg::csev_in_t  in_data,
  output logic                out_valid,
  output csev_pkg::csev_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import csev_pkg::*;

  localparam int SH_LEN = 10;

  // configuration registers
  logic             kind_r;
  logic [CNT_W-1:0] count_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_BSPL;
      count_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_KIND) kind_r  <= pwdata[0];
      else                      count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_KIND) ? {31'b0, kind_r} : {25'b0, count_r};

  // stage 0: clamp count and parameter, pick segment count
  logic             accept;
  logic [CNT_W-1:0] n_sat;
  logic             few;
  logic [CNT_W-1:0] nseg_full;
  logic [T_W-1:0]   t_sat;

  assign accept = start && !busy;

  always_comb begin
    n_sat     = (count_r > CNT_MAX) ? CNT_MAX : count_r;
    few       = (kind_r == KIND_BSPL) ? (n_sat < 7'd4) : (n_sat < 7'd2);
    nseg_full = (kind_r == KIND_BSPL) ? n_sat - 7'd3 : n_sat - 7'd1;
    t_sat     = (in_data.t_param > T_ONE) ? T_ONE : in_data.t_param;
  end

  // stage 1 registers
  logic              s1_vld_r, s1_cmd_r, s1_kind_r, s1_few_r;
  logic [ADDR_W-1:0] s1_idx_r, s1_nseg_r;
  logic [PT_W-1:0]   s1_pt_r;
  logic [T_W-1:0]    s1_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= accept;
  end

  always_ff @(posedge clk) begin
    s1_cmd_r  <= in_data.cmd;
    s1_kind_r <= kind_r;
    s1_few_r  <= few;
    s1_idx_r  <= in_data.point_index;
    s1_nseg_r <= nseg_full[ADDR_W-1:0];
    s1_pt_r   <= {in_data.point_x, in_data.point_y, in_data.point_z};
    s1_t_r    <= t_sat;
  end

  // stage 1: scale parameter by the segment count, split, clamp the end
  logic [22:0]       scaled;
  logic [ADDR_W-1:0] seg_nxt;
  logic [T_W-1:0]    f_nxt;

  always_comb begin
    scaled  = {17'b0, s1_nseg_r} * {6'b0, s1_t_r};
    seg_nxt = scaled[21:16];
    f_nxt   = {1'b0, scaled[15:0]};
    if (scaled[22:16] >= {1'b0, s1_nseg_r}) begin
      seg_nxt = s1_nseg_r - 6'd1;
      f_nxt   = T_ONE;
    end
  end

  // stage 2 registers
  logic              s2_vld_r, s2_cmd_r, s2_kind_r, s2_few_r;
  logic [ADDR_W-1:0] s2_idx_r, s2_nseg_r, s2_seg_r;
  logic [PT_W-1:0]   s2_pt_r;
  logic [T_W-1:0]    s2_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_cmd_r  <= s1_cmd_r;
    s2_kind_r <= s1_kind_r;
    s2_few_r  <= s1_few_r;
    s2_idx_r  <= s1_idx_r;
    s2_nseg_r <= s1_nseg_r;
    s2_seg_r  <= seg_nxt;
    s2_pt_r   <= s1_pt_r;
    s2_f_r    <= f_nxt;
  end

  // stage 2: neighbor addresses; writes land here too so order holds
  logic [ADDR_W-1:0] rd_addr [NBANK];
  logic [PT_W-1:0]   rd_data [NBANK];
  logic              wr_en;

  assign wr_en = s2_vld_r && (s2_cmd_r == CMD_WRITE);

  always_comb begin
    if (s2_kind_r == KIND_BSPL) begin
      for (int i = 0; i < NBANK; i++) begin
        rd_addr[i] = s2_seg_r + ADDR_W'(i);
      end
    end else begin
      rd_addr[0] = (s2_seg_r == '0) ? s2_seg_r : s2_seg_r - 6'd1;
      rd_addr[1] = s2_seg_r;
      rd_addr[2] = s2_seg_r + 6'd1;
      // duplicate the last point on the last segment
      rd_addr[3] = (s2_seg_r == s2_nseg_r - 6'd1) ? s2_seg_r + 6'd1 : s2_seg_r + 6'd2;
    end
  end

  csev_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s2_idx_r),
    .wr_data (s2_pt_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  weight_t w [4];

  csev_weights u_weights (
    .clk  (clk),
    .frac (s2_f_r),
    .kind (s2_kind_r),
    .w    (w)
  );

  // hold points two stages to meet the weights
  logic [PT_W-1:0] pts_d1_r [NBANK];
  logic [PT_W-1:0] pts_d2_r [NBANK];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NBANK; i++) begin
      pts_d1_r[i] <= rd_data[i];
      pts_d2_r[i] <= pts_d1_r[i];
    end
  end

  // evaluate valid, kind and too-few flags travel down the pipe
  logic [SH_LEN-1:0] ev_sh_r, kind_sh_r, few_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ev_sh_r <= '0;
    else        ev_sh_r <= {ev_sh_r[SH_LEN-2:0], s2_vld_r && (s2_cmd_r == CMD_EVAL)};
  end

  always_ff @(posedge clk) begin
    kind_sh_r <= {kind_sh_r[SH_LEN-2:0], s2_kind_r};
    few_sh_r  <= {few_sh_r[SH_LEN-2:0], s2_few_r};
  end

  coord_t px [4], py [4], pz [4];
  coord_t rx, ry, rz;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[i] = pts_d2_r[i][3*COORD_WIDTH-1:2*COORD_WIDTH];
      py[i] = pts_d2_r[i][2*COORD_WIDTH-1:COORD_WIDTH];
      pz[i] = pts_d2_r[i][COORD_WIDTH-1:0];
    end
  end

  csev_combine u_comb_x (.clk(clk), .kind(kind_sh_r[2]), .p(px), .w(w), .res(rx));
  csev_combine u_comb_y (.clk(clk), .kind(kind_sh_r[2]), .p(py), .w(w), .res(ry));
  csev_combine u_comb_z (.clk(clk), .kind(kind_sh_r[2]), .p(pz), .w(w), .res(rz));

  // result transfer: zero the point when the table is too short
  assign out_valid               = ev_sh_r[SH_LEN-1];
  assign out_data.too_few_points = few_sh_r[SH_LEN-1];
  assign out_data.out_x          = few_sh_r[SH_LEN-1] ? '0 : rx;
  assign out_data.out_y          = few_sh_r[SH_LEN-1] ? '0 : ry;
  assign out_data.out_z          = few_sh_r[SH_LEN-1] ? '0 : rz;

  // every evaluate transfer yields a result
  a_eval_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.cmd == CMD_EVAL) |-> ##12 out_valid)
    else $error("evaluate lost in pipeline");

  // a write produces no result in its slot
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.cmd == CMD_WRITE) |-> ##12 !out_valid)
    else $error("write produced a result");

  // segment split stays inside the table
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_cmd_r == CMD_EVAL && !s2_few_r) |-> (s2_seg_r < s2_nseg_r))
    else $error("segment index out of range");

  // flagged results carry a zero point
  a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.too_few_points) |->
      (out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0))
    else $error("too-few result not zero");

endmodule

/* design/csev_store.sv */
// Control point table: four banks written alike, one registered read port each.
module csev_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [csev_pkg::ADDR_W-1:0] wr_addr,
  input  logic [csev_pkg::PT_W-1:0] wr_data,
  input  logic [csev_pkg::ADDR_W-1:0] rd_addr [csev_pkg::NBANK],
  output logic [csev_pkg::PT_W-1:0] rd_data [csev_pkg::NBANK]
);
  import csev_pkg::*;

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic [PT_W-1:0] mem [MAX_POINTS];

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      rd_data[b] <= mem[rd_addr[b]];
    end
  end

endmodule

/* design/csev_weights.sv */
// Basis weights in Q48 from the segment fraction, three register stages.
module csev_weights (
  input  logic                     clk,
  input  logic [csev_pkg::T_W-1:0] frac,
  input  logic                     kind,
  output csev_pkg::weight_t        w [4]
);
  import csev_pkg::*;

  localparam logic signed [53:0] ONE_Q = 54'sh1000000000000;

  logic [T_W-1:0]   fa_r;
  logic [32:0]      f2_r;
  logic             kind_a_r, kind_b_r;
  logic [48:0]      t1_r, t2_r, t3_r;
  logic [33:0]      f2_full;
  logic [48:0]      f3_full;
  logic signed [53:0] a1, a2, a3;
  logic signed [53:0] w_nxt [4];

  assign f2_full = {17'b0, frac} * {17'b0, frac};
  assign f3_full = {16'b0, f2_r} * {32'b0, fa_r};

  always_ff @(posedge clk) begin
    fa_r     <= frac;
    f2_r     <= f2_full[32:0];
    kind_a_r <= kind;
    t1_r     <= {fa_r, 32'b0};
    t2_r     <= {f2_r, 16'b0};
    t3_r     <= f3_full;
    kind_b_r <= kind_a_r;
  end

  always_comb begin
    a1 = $signed({5'b0, t1_r});
    a2 = $signed({5'b0, t2_r});
    a3 = $signed({5'b0, t3_r});
    if (kind_b_r == KIND_BSPL) begin
      w_nxt[0] = -a3 + 3 * a2 - 3 * a1 + ONE_Q;
      w_nxt[1] = 3 * a3 - 6 * a2 + 4 * ONE_Q;
      w_nxt[2] = -3 * a3 + 3 * a2 + 3 * a1 + ONE_Q;
      w_nxt[3] = a3;
    end else begin
      w_nxt[0] = -a3 + 2 * a2 - a1;
      w_nxt[1] = 3 * a3 - 5 * a2 + 2 * ONE_Q;
      w_nxt[2] = -3 * a3 + 4 * a2 + a1;
      w_nxt[3] = a3 - a2;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      w[i] <= w_nxt[i][W_W-1:0];
    end
  end

endmodule

/* design/csev_combine.sv */
// One coordinate: weighted sum, round, divide by the basis divisor, saturate.
module csev_combine (
  input  logic              clk,
  input  logic              kind,
  input  csev_pkg::coord_t  p [4],
  input  csev_pkg::weight_t w [4],
  output csev_pkg::coord_t  res
);
  import csev_pkg::*;

  localparam logic signed [87:0] HALF_BS = 88'sh3000000000000;
  localparam logic signed [87:0] HALF_CR = 88'sh1000000000000;
  localparam logic signed [36:0] R_HI    = 37'sd6442450946;
  localparam logic signed [36:0] R_LO    = -37'sd6442450944;
  localparam logic signed [36:0] R_OFS   = 37'sd6442450944;
  localparam logic signed [36:0] C_MAX   = 37'sd2147483647;
  localparam logic signed [36:0] C_MIN   = -37'sd2147483648;
  localparam logic [17:0]        DIV3_K  = 18'd174763;

  logic signed [58:0] pl_r [4];
  logic signed [57:0] ph_r [4];
  logic signed [60:0] sl_r;
  logic signed [59:0] sh_r;
  logic signed [36:0] r_r;
  logic [35:0]        prodh_r;
  logic [17:0]        uh_r;
  logic [16:0]        ul_r;
  logic [16:0]        qh_r, qh2_r;
  logic [18:0]        v_r;
  logic [36:0]        prodl_r;
  coord_t             cr_r, cr2_r, cr3_r;
  logic [6:1]         kind_r;

  logic signed [87:0] acc;
  logic signed [36:0] rc, u_s;
  logic [16:0]        qh;
  logic [18:0]        rh3;
  logic [33:0]        q;
  coord_t             cr_nxt;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      pl_r[i] <= p[i] * $signed({1'b0, w[i][25:0]});
      ph_r[i] <= p[i] * $signed(w[i][51:26]);
    end
    sl_r <= 61'(pl_r[0]) + 61'(pl_r[1]) + 61'(pl_r[2]) + 61'(pl_r[3]);
    sh_r <= 60'(ph_r[0]) + 60'(ph_r[1]) + 60'(ph_r[2]) + 60'(ph_r[3]);
    kind_r <= {kind_r[5:1], kind};
  end

  // round: add half of the divisor step, drop 49 fraction bits
  always_comb begin
    acc = (88'(sh_r) <<< 26) + 88'(sl_r) + ((kind_r[2] == KIND_BSPL) ? HALF_BS : HALF_CR);
  end

  always_ff @(posedge clk) begin
    r_r <= acc[85:49];
  end

  // B-spline: clamp, offset to nonnegative, divide by 3 in two digits; CR: saturate
  always_comb begin
    rc = r_r;
    if (r_r > R_HI) rc = R_HI;
    if (r_r < R_LO) rc = R_LO;
    u_s = rc + R_OFS;
    cr_nxt = r_r[COORD_WIDTH-1:0];
    if (r_r > C_MAX) cr_nxt = C_MAX[COORD_WIDTH-1:0];
    if (r_r < C_MIN) cr_nxt = C_MIN[COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    prodh_r <= u_s[34:17] * DIV3_K;
    uh_r    <= u_s[34:17];
    ul_r    <= u_s[16:0];
    cr_r    <= cr_nxt;
  end

  always_comb begin
    qh  = prodh_r[35:19];
    rh3 = 19'(uh_r) - 19'(qh) - 19'({qh, 1'b0});
  end

  always_ff @(posedge clk) begin
    v_r     <= {rh3[1:0], ul_r};
    qh_r    <= qh;
    cr2_r   <= cr_r;
    prodl_r <= v_r * {1'b0, DIV3_K};
    qh2_r   <= qh_r;
    cr3_r   <= cr2_r;
  end

  always_comb begin
    q = {qh2_r, 17'b0} + 34'(prodl_r[35:19]);
  end

  always_ff @(posedge clk) begin
    if (kind_r[6] == KIND_CR) begin
      res <= cr3_r;
    end else if (q[33:32] != 2'b00) begin
      res <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      res <= {~q[31], q[30:0]};
    end
  end

endmodule
